// ===== rtl/lru_page_replacement_unit_defines.svh =====
// Assertion helpers for the LRU page replacement unit
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication
`define LRU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lru_pr_pkg.sv =====
package lru_pr_pkg;

   localparam int CFG_W       = 4;
   localparam int FRAME_IDX_W = 3;
   localparam int COUNT_W     = 32;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   typedef struct packed {
      logic load;       // latch request, restart scan
      logic scan_step;  // read one frame, advance index
      logic commit;     // write table, counters, response
   } cmd_type;

   typedef struct packed {
      logic scan_last;  // index points at last active frame
   } status_type;

endpackage

// ===== rtl/lru_pr_ctrl.sv =====
module lru_pr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lru_pr_pkg::status_type status,
   output lru_pr_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN:  state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign cmd.load      = (state_ff == S_IDLE) && start;
   assign cmd.scan_step = (state_ff == S_SCAN);
   assign cmd.commit    = (state_ff == S_COMMIT);

endmodule

// ===== rtl/lru_pr_dpath.sv =====
module lru_pr_dpath #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lru_pr_pkg::cmd_type                   cmd,
   output lru_pr_pkg::status_type                status,
   input  logic [PAGE_BITS-1:0]                  req_page_number,
   input  logic                                  req_last_request,
   input  logic                                  csr_valid,
   input  logic [lru_pr_pkg::CFG_W-1:0]          csr_data,
   output logic                                  rsp_strobe,
   output logic                                  rsp_hit,
   output logic [lru_pr_pkg::FRAME_IDX_W-1:0]    rsp_frame_index,
   output logic [lru_pr_pkg::COUNT_W-1:0]        rsp_fault_count
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CMP_W = 8;
   localparam int CNT_W = lru_pr_pkg::COUNT_W;

   // frame storage, read one entry per cycle during the scan
   logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
   logic [CNT_W-1:0]     time_mem [MAX_FRAMES];

   logic [lru_pr_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [MAX_FRAMES-1:0]        valid_ff, valid_in;
   logic [CNT_W-1:0]             request_number_ff, request_number_in;
   logic [CNT_W-1:0]             fault_total_ff, fault_total_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         cmp_valid_ff;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic [PAGE_BITS-1:0]         page_ff, page_in;
   logic                         last_ff, last_in;
   logic [PAGE_BITS-1:0]         page_rd_ff;
   logic [CNT_W-1:0]             time_rd_ff;

   logic                         hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]             hit_slot_ff, hit_slot_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_slot_ff, free_slot_in;
   logic                         old_found_ff, old_found_in;
   logic [IDX_W-1:0]             old_slot_ff, old_slot_in;
   logic [CNT_W-1:0]             old_time_ff, old_time_in;

   logic                         rsp_strobe_ff;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [lru_pr_pkg::FRAME_IDX_W-1:0] rsp_frame_index_ff, rsp_frame_index_in;
   logic [CNT_W-1:0]             rsp_fault_count_ff, rsp_fault_count_in;

   logic [CMP_W-1:0]             cfg_ext;
   logic [IDX_W-1:0]             active_last;
   logic                         frame_is_valid;
   logic [IDX_W-1:0]             slot;
   logic                         miss_write;

   // clamp frame count to 1..MAX_FRAMES
   always_comb begin
      cfg_ext = CMP_W'(cfg_ff);
      if (cfg_ext == '0) begin
         active_last = '0;
      end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
         active_last = IDX_W'(MAX_FRAMES - 1);
      end else begin
         active_last = IDX_W'(cfg_ext - CMP_W'(1));
      end
   end

   assign status.scan_last = (idx_ff == active_last);
   assign frame_is_valid   = valid_ff[cmp_idx_ff];

   always_comb begin
      cfg_in            = csr_valid ? csr_data : cfg_ff;
      page_in           = page_ff;
      last_in           = last_ff;
      idx_in            = idx_ff;
      hit_found_in      = hit_found_ff;
      hit_slot_in       = hit_slot_ff;
      free_found_in     = free_found_ff;
      free_slot_in      = free_slot_ff;
      old_found_in      = old_found_ff;
      old_slot_in       = old_slot_ff;
      old_time_in       = old_time_ff;
      valid_in          = valid_ff;
      request_number_in = request_number_ff;
      fault_total_in    = fault_total_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_frame_index_in = rsp_frame_index_ff;
      rsp_fault_count_in = rsp_fault_count_ff;

      if (cmd.load) begin
         page_in       = req_page_number;
         last_in       = req_last_request;
         idx_in        = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         old_found_in  = 1'b0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      // one frame compared per cycle, data from the registered read
      if (cmp_valid_ff) begin
         if (frame_is_valid && (page_rd_ff == page_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_slot_in  = cmp_idx_ff;
         end
         if (!frame_is_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = cmp_idx_ff;
         end
         // strict less-than keeps the lowest index on ties
         if (frame_is_valid && (!old_found_ff || (time_rd_ff < old_time_ff))) begin
            old_found_in = 1'b1;
            old_slot_in  = cmp_idx_ff;
            old_time_in  = time_rd_ff;
         end
      end

      priority if (hit_found_ff) begin
         slot = hit_slot_ff;
      end else if (free_found_ff) begin
         slot = free_slot_ff;
      end else begin
         slot = old_slot_ff;
      end
      miss_write = cmd.commit && !hit_found_ff;

      if (cmd.commit) begin
         if (!hit_found_ff) begin
            valid_in[slot] = 1'b1;
            if (fault_total_ff != '1) fault_total_in = fault_total_ff + CNT_W'(1);
         end
         if (request_number_ff != '1) request_number_in = request_number_ff + CNT_W'(1);
         rsp_hit_in         = hit_found_ff;
         rsp_frame_index_in = lru_pr_pkg::FRAME_IDX_W'(slot);
         rsp_fault_count_in = fault_total_in;
         // end of sequence: table and counters clear after this response
         if (last_ff) begin
            valid_in          = '0;
            request_number_in = '0;
            fault_total_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff            <= lru_pr_pkg::CFG_RESET;
         valid_ff          <= '0;
         request_number_ff <= '0;
         fault_total_ff    <= '0;
         idx_ff            <= '0;
         cmp_valid_ff      <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         cfg_ff            <= cfg_in;
         valid_ff          <= valid_in;
         request_number_ff <= request_number_in;
         fault_total_ff    <= fault_total_in;
         idx_ff            <= idx_in;
         cmp_valid_ff      <= cmd.scan_step;
         rsp_strobe_ff     <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff         <= idx_ff;
      page_ff            <= page_in;
      last_ff            <= last_in;
      hit_found_ff       <= hit_found_in;
      hit_slot_ff        <= hit_slot_in;
      free_found_ff      <= free_found_in;
      free_slot_ff       <= free_slot_in;
      old_found_ff       <= old_found_in;
      old_slot_ff        <= old_slot_in;
      old_time_ff        <= old_time_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_frame_index_ff <= rsp_frame_index_in;
      rsp_fault_count_ff <= rsp_fault_count_in;
   end

   always_ff @(posedge clock) begin
      if (miss_write) page_mem[slot] <= page_ff;
      if (cmd.commit) time_mem[slot] <= request_number_ff;
      page_rd_ff <= page_mem[idx_ff];
      time_rd_ff <= time_mem[idx_ff];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_index = rsp_frame_index_ff;
   assign rsp_fault_count = rsp_fault_count_ff;

endmodule

// ===== rtl/lru_page_replacement_unit.sv =====
// Sequence: after the accepting edge the controller scans the active frames, then passes
//   through a drain state and a commit state; the response strobe is registered from commit.
// Scan: one frame per cycle over the single read port of the frame tables; no new
//   request is taken until busy drops, and busy is low while the strobe is shown.
// Reset: synchronous, clears valid bits and counters, frame count returns to 8.
//   Responses are pulses; the receiver cannot stall them.
module lru_page_replacement_unit #(
   parameter int MAX_FRAMES = 8,
   parameter int PAGE_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [PAGE_BITS-1:0]               req_page_number,
   input  logic                               req_last_request,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lru_pr_pkg::CFG_W-1:0]       csr_data,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic [lru_pr_pkg::FRAME_IDX_W-1:0] rsp_frame_index,
   output logic [lru_pr_pkg::COUNT_W-1:0]     rsp_fault_count
);

   lru_pr_pkg::cmd_type    cmd;
   lru_pr_pkg::status_type status;

   assign csr_ready = 1'b1;

   lru_pr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lru_pr_dpath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_page_number  (req_page_number),
      .req_last_request (req_last_request),
      .csr_valid        (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_fault_count  (rsp_fault_count)
   );

endmodule

// ===== rtl/lru_pr_checker.sv =====
`include "lru_page_replacement_unit_defines.svh"

module lru_pr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic [31:0] rsp_fault_count
);

   // an accepted transaction keeps the unit busy until its response
   `LRU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not raise busy")
   // the response appears exactly when busy drops
   `LRU_ASSERT_NOW(a_fell_strobe, clock, reset, $fell(busy), rsp_strobe, "busy fell without a response")
   `LRU_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "response while busy")
   // a fault always leaves a nonzero fault count
   `LRU_ASSERT_NOW(a_fault_count, clock, reset, rsp_strobe && !rsp_hit, rsp_fault_count != 32'd0,
      "fault reported with zero count")

endmodule

bind lru_page_replacement_unit lru_pr_checker u_lru_pr_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_hit         (rsp_hit),
   .rsp_fault_count (rsp_fault_count)
);

// ===== verif/lru_page_replacement_unit_tb.sv =====
`timescale 1ns / 100ps

module lru_page_replacement_unit_tb;

   localparam int TB_FRAMES   = 8;
   localparam int PAGE_W      = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 16;

   typedef struct packed {
      logic                               hit;
      logic [lru_pr_pkg::FRAME_IDX_W-1:0] frame;
      logic [lru_pr_pkg::COUNT_W-1:0]     faults;
   } lookup_type;

   // Tracks the frame table and holds the lookups still owed by the block.
   class page_table_sb_type;
      logic [PAGE_W-1:0]              page_of [TB_FRAMES];
      bit                             resident [TB_FRAMES];
      logic [lru_pr_pkg::COUNT_W-1:0] used_at [TB_FRAMES];
      logic [lru_pr_pkg::COUNT_W-1:0] request_no;
      logic [lru_pr_pkg::COUNT_W-1:0] faults;
      logic [lru_pr_pkg::CFG_W-1:0]   frame_count;
      lookup_type                     outstanding[$];
      int                             errors;
      int                             checked;
      int                             hits;
      int                             sequences;

      function new();
         frame_count = lru_pr_pkg::CFG_RESET;
         errors      = 0;
         checked     = 0;
         hits        = 0;
         sequences   = 0;
         clear();
      endfunction

      function void clear();
         foreach (resident[i]) resident[i] = 1'b0;
         request_no = '0;
         faults     = '0;
      endfunction

      function int active();
         if (frame_count == 0) return 1;
         if (frame_count > TB_FRAMES) return TB_FRAMES;
         return int'(frame_count);
      endfunction

      function void set_frame_count(logic [lru_pr_pkg::CFG_W-1:0] value);
         frame_count = value;
      endfunction

      function int pending();
         return outstanding.size();
      endfunction

      function void note_request(logic [PAGE_W-1:0] page, logic last);
         int                             n;
         int                             slot;
         bit                             found;
         logic [lru_pr_pkg::COUNT_W-1:0] oldest;
         lookup_type                     res;
         n     = active();
         slot  = 0;
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!found && resident[i] && page_of[i] == page) begin
               found = 1'b1;
               slot  = i;
            end
         end
         res.hit = found;
         if (!found) begin
            if (faults != '1) faults++;
            // free frame first, lowest index
            for (int i = 0; i < n; i++) begin
               if (!found && !resident[i]) begin
                  found = 1'b1;
                  slot  = i;
               end
            end
            if (!found) begin
               oldest = used_at[0];
               slot   = 0;
               for (int i = 1; i < n; i++) begin
                  if (used_at[i] < oldest) begin
                     oldest = used_at[i];
                     slot   = i;
                  end
               end
            end
            page_of[slot]  = page;
            resident[slot] = 1'b1;
         end
         used_at[slot] = request_no;
         if (request_no != '1) request_no++;
         res.frame  = slot[lru_pr_pkg::FRAME_IDX_W-1:0];
         res.faults = faults;
         outstanding.push_back(res);
         if (last) begin
            sequences++;
            clear();
         end
      endfunction

      function void check_response(logic hit, logic [lru_pr_pkg::FRAME_IDX_W-1:0] frame,
                                   logic [lru_pr_pkg::COUNT_W-1:0] fault_count);
         lookup_type exp;
         if (outstanding.size() == 0) begin
            errors++;
            $display("%0t: response with no request outstanding: hit=%0b frame=%0d faults=%0d",
                     $time, hit, frame, fault_count);
            return;
         end
         exp = outstanding.pop_front();
         checked++;
         if (exp.hit) hits++;
         if (hit !== exp.hit) begin
            errors++;
            $display("%0t: hit expected %0b actual %0b", $time, exp.hit, hit);
         end
         if (frame !== exp.frame) begin
            errors++;
            $display("%0t: frame_index expected %0d actual %0d", $time, exp.frame, frame);
         end
         if (fault_count !== exp.faults) begin
            errors++;
            $display("%0t: fault_count expected %0d actual %0d", $time, exp.faults,
                     fault_count);
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [PAGE_W-1:0]                  req_page_number;
   logic                               req_last_request;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [lru_pr_pkg::CFG_W-1:0]       csr_data;
   logic                               rsp_strobe;
   logic                               rsp_hit;
   logic [lru_pr_pkg::FRAME_IDX_W-1:0] rsp_frame_index;
   logic [lru_pr_pkg::COUNT_W-1:0]     rsp_fault_count;

   page_table_sb_type table_sb = new();
   int                stall_cycles = 0;
   int                settings_used = 0;

   lru_page_replacement_unit #(
      .MAX_FRAMES(TB_FRAMES),
      .PAGE_BITS (PAGE_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_page_number(req_page_number),
      .req_last_request(req_last_request),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_frame_index(rsp_frame_index),
      .rsp_fault_count(rsp_fault_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // monitor: every transaction is sampled at the edge that accepts it
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) table_sb.note_request(req_page_number, req_last_request);
         if (rsp_strobe) table_sb.check_response(rsp_hit, rsp_frame_index, rsp_fault_count);
         if (csr_valid && csr_ready) table_sb.set_frame_count(csr_data);
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, table_sb.pending());
      $display("lru_page_replacement_unit: mismatch");
      $finish;
   end

   task automatic send_request(input logic [PAGE_W-1:0] page, input logic last);
      start            <= 1'b1;
      req_page_number  <= page;
      req_last_request <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // only while idle: no request in flight and nothing owed
   task automatic write_frame_count(input logic [lru_pr_pkg::CFG_W-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (table_sb.pending() != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // mostly a working set of a few pages so hits and LRU evictions dominate
   task automatic run_phase(input int items, input bit steady);
      logic [PAGE_W-1:0] pool [12];
      logic [PAGE_W-1:0] page;
      logic              last;
      int                pool_size;
      int                burst;
      pool_size = $urandom_range(2, 12);
      foreach (pool[i]) pool[i] = PAGE_W'($urandom);
      burst = $urandom_range(1, 8);
      for (int k = 0; k < items; k++) begin
         case ($urandom_range(0, 19))
            0:       page = PAGE_W'($urandom);
            1:       page = '0;
            2:       page = '1;
            default: page = pool[$urandom_range(0, pool_size - 1)];
         endcase
         last = ($urandom_range(0, 24) == 0);
         send_request(page, last);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            if (!steady) hold_off($urandom_range(1, 14));
         end
      end
   endtask

   initial begin
      int frame_settings [12] = '{1, 0, 15, 8, 3, 9, 5, 2, 7, 4, 6, 12};
      reset            <= 1'b1;
      start            <= 1'b0;
      req_page_number  <= '0;
      req_last_request <= 1'b0;
      csr_valid        <= 1'b0;
      csr_data         <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill all eight frames from empty, then hit and evict
      send_request(16'h0000, 1'b0);
      send_request(16'hFFFF, 1'b0);
      for (int p = 1; p <= 6; p++) send_request(PAGE_W'(p), 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'hAAAA, 1'b0);
      send_request(16'h5555, 1'b0);
      hold_off(3);
      // shrink mid-sequence: upper frames are ignored but keep their pages
      write_frame_count(lru_pr_pkg::CFG_W'(2));
      send_request(16'h0004, 1'b0);
      send_request(16'hAAAA, 1'b0);
      write_frame_count(lru_pr_pkg::CFG_W'(8));
      send_request(16'h0004, 1'b0);
      send_request(16'h0005, 1'b0);
      send_request(16'h1234, 1'b1);
      send_request(16'hFFFF, 1'b0);
      send_request(16'hFFFF, 1'b1);

      for (int ph = 0; ph < 12; ph++) begin
         write_frame_count(lru_pr_pkg::CFG_W'(frame_settings[ph]));
         run_phase(50, ($urandom_range(0, 3) == 0));
      end
      write_frame_count(lru_pr_pkg::CFG_W'($urandom_range(0, 15)));
      run_phase(20, 1'b0);

      start <= 1'b0;
      @(posedge clock);
      while (table_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("checked %0d lookups (%0d hits, %0d faults), %0d sequences closed",
               table_sb.checked, table_sb.hits, table_sb.checked - table_sb.hits,
               table_sb.sequences);
      $display("frame count written %0d times, including 0, 1, 8 and 15", settings_used);
      if (table_sb.pending() != 0)
         $display("%0t: %0d expected responses never arrived", $time, table_sb.pending());
      if (table_sb.errors == 0 && table_sb.pending() == 0)
         $display("lru_page_replacement_unit: match");
      else
         $display("lru_page_replacement_unit: mismatch");
      $finish;
   end

endmodule
